[rtl/fpba_pkg.sv]
package fpba_pkg;

  // Default sizing of the free-space table
  localparam int unsigned NUM_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Beat field widths
  localparam int unsigned OP_W    = 1;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned FIELD_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned BCNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

[rtl/fpba_if.sv]
interface fpba_req_if;
  import fpba_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   block_index;
  logic [FIELD_W-1:0] block_size;
  logic [FIELD_W-1:0] request_size;

  modport source (output valid, operation, block_index, block_size, request_size,
                  input ready);
  modport sink   (input valid, operation, block_index, block_size, request_size,
                  output ready);
endinterface

interface fpba_rsp_if;
  import fpba_pkg::*;

  logic               valid;
  logic               ready;
  logic               granted;
  logic [IDX_W-1:0]   chosen_block;
  logic [FIELD_W-1:0] space_left;

  modport source (output valid, granted, chosen_block, space_left, input ready);
  modport sink   (input valid, granted, chosen_block, space_left, output ready);
endinterface

[rtl/fit_policy_block_allocator.sv]
// Load beat: the capacity is written at the accepting edge, no result.
// Allocate beat: the scan reads n = min(block_count, NUM_BLOCKS) entries of the
// free-space RAM, one entry per cycle through its single read port, then writes
// the free space left back to the chosen entry, if any, and registers the result;
// the next beat is taken once the block is back in idle.
// Reset: fit_mode = first fit, block_count = 16; table contents undefined.
module fit_policy_block_allocator #(
  parameter int unsigned NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fpba_req_if.sink                        in_if,
  fpba_rsp_if.source                      out_if
);

  import fpba_pkg::*;

  localparam int unsigned ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] fit_mode_q;
  logic [BCNT_W-1:0] blk_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FIT_FIRST;
      blk_cnt_q  <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIT_MODE:    fit_mode_q <= cfg_wdata_i[MODE_W-1:0];
        REG_BLOCK_COUNT: blk_cnt_q  <= cfg_wdata_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and scan state
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    n_q, n_d;          // blocks to scan for this request
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;  // next address to read
  logic                rvalid_q;          // RAM data arriving this cycle
  logic [ADDR_W-1:0]   rd_idx_q;          // address of that data
  logic                found_q, found_d;
  logic [ADDR_W-1:0]   pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;   // free space of current pick
  logic [SIZE_BITS-1:0] req_q, req_d;

  logic                out_valid_q, out_valid_d;
  logic                out_granted_q, out_granted_d;
  logic [IDX_W-1:0]    out_block_q, out_block_d;
  logic [FIELD_W-1:0]  out_space_q, out_space_d;

  logic                 acc;
  logic                 out_free;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [EXT_W-1:0]     ld_idx;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  assign in_if.ready = (state_q == ST_IDLE);
  assign acc         = in_if.valid & in_if.ready;
  assign out_free    = ~out_valid_q | out_if.ready;
  assign ld_idx      = EXT_W'(in_if.block_index);
  assign left        = best_q - req_q;

  // One read per scan cycle until all n entries are issued
  assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < n_q);
  assign rd_addr = rd_cnt_q[ADDR_W-1:0];

  // Qualifying entry under the current rule; first fit keeps the first hit,
  // unused mode code behaves as first fit. Ties keep the lower index.
  always_comb begin
    take = 1'b0;
    if (rvalid_q && (rd_data >= req_q)) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (fit_mode_q == FIT_BEST) begin
        take = (rd_data < best_q);
      end else if (fit_mode_q == FIT_WORST) begin
        take = (rd_data > best_q);
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    rd_cnt_d      = rd_cnt_q;
    found_d       = found_q;
    pick_d        = pick_q;
    best_d        = best_q;
    req_d         = req_q;
    out_valid_d   = out_valid_q & ~out_if.ready;
    out_granted_d = out_granted_q;
    out_block_d   = out_block_q;
    out_space_d   = out_space_q;
    wr_en         = 1'b0;
    wr_addr       = ld_idx[ADDR_W-1:0];
    wr_data       = SIZE_BITS'(in_if.block_size);

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_if.operation == OP_LOAD) begin
            // Loads beyond the table are dropped
            wr_en = (32'(ld_idx) < NUM_BLOCKS);
          end else begin
            if (32'(blk_cnt_q) > NUM_BLOCKS) begin
              n_d = CNT_W'(NUM_BLOCKS);
            end else begin
              n_d = CNT_W'(blk_cnt_q);
            end
            rd_cnt_d = '0;
            found_d  = 1'b0;
            req_d    = SIZE_BITS'(in_if.request_size);
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          found_d = 1'b1;
          pick_d  = rd_idx_q;
          best_d  = rd_data;
        end
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end else begin
          // Last entry is evaluated this cycle; nothing else in flight
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          wr_en         = found_q;
          wr_addr       = pick_q;
          wr_data       = left;
          out_valid_d   = 1'b1;
          out_granted_d = found_q;
          out_block_d   = found_q ? IDX_W'(pick_q) : '0;
          out_space_d   = found_q ? FIELD_W'(left) : '0;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      rd_cnt_q    <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      rd_cnt_q    <= rd_cnt_d;
      rvalid_q    <= rd_en;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_addr;
    pick_q        <= pick_d;
    best_q        <= best_d;
    req_q         <= req_d;
    out_granted_q <= out_granted_d;
    out_block_q   <= out_block_d;
    out_space_q   <= out_space_d;
  end

  // Free-space table
  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_if.valid        = out_valid_q;
  assign out_if.granted      = out_granted_q;
  assign out_if.chosen_block = out_block_q;
  assign out_if.space_left   = out_space_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_cnt_q <= n_q))
    else $error("scan address ran past block count");

  a_pick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && found_q) |-> (CNT_W'(pick_q) < n_q))
    else $error("picked block outside scanned range");

  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && found_q) |-> (best_q >= req_q))
    else $error("picked block smaller than request");

  a_alloc_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_if.operation == OP_ALLOC) |=> (state_q == ST_SCAN))
    else $error("allocate did not start a scan");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished allocate produced no result");

endmodule

[rtl/fpba_ram.sv]
module fpba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
